// File: rtl/knf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knf_pkg
// Types, widths and domain tables shared by the Kuwahara-Nagao filter.
// ----------------------------------------------------------------------------
package knf_pkg;

    localparam int WIN_DIM   = 5;
    localparam int WIN_N     = WIN_DIM * WIN_DIM;
    localparam int STORED    = WIN_DIM - 1;
    localparam int DOM_N     = 9;
    localparam int DOM_SIZE  = 9;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 12;
    localparam int SQ_W      = 20;
    localparam int COST_W    = 23;
    localparam int CNT_W     = 3;
    localparam int POS_W     = 5;

    // floor(s / 9) == (s * RECIP9) >> RECIP_SH for every s below 2296
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 16;
    localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef pix_t [WIN_N-1:0]  win_t;
    typedef pix_t [DOM_SIZE-1:0] dom_pix_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [SUM_W-1:0]  sum;
    } lane_res_t;

    typedef lane_res_t [DOM_N-1:0] lane_res_arr_t;

    // Domains in priority order: east, north, south, west, centre,
    // north-east, south-east, south-west, north-west (row*5 + col).
    localparam logic [3:0] DOM_LEN [DOM_N] = '{
        4'd7, 4'd7, 4'd7, 4'd7, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7
    };

    localparam pos_t DOM_POS [DOM_N][DOM_SIZE] = '{
        '{5'd12, 5'd8,  5'd13, 5'd18, 5'd9,  5'd14, 5'd19, 5'd0,  5'd0 },
        '{5'd12, 5'd1,  5'd2,  5'd3,  5'd6,  5'd7,  5'd8,  5'd0,  5'd0 },
        '{5'd12, 5'd16, 5'd17, 5'd18, 5'd21, 5'd22, 5'd23, 5'd0,  5'd0 },
        '{5'd12, 5'd5,  5'd10, 5'd15, 5'd6,  5'd11, 5'd16, 5'd0,  5'd0 },
        '{5'd12, 5'd6,  5'd7,  5'd8,  5'd11, 5'd13, 5'd16, 5'd17, 5'd18},
        '{5'd3,  5'd4,  5'd7,  5'd8,  5'd9,  5'd12, 5'd13, 5'd0,  5'd0 },
        '{5'd12, 5'd13, 5'd17, 5'd18, 5'd19, 5'd23, 5'd24, 5'd0,  5'd0 },
        '{5'd11, 5'd12, 5'd15, 5'd16, 5'd17, 5'd20, 5'd21, 5'd0,  5'd0 },
        '{5'd0,  5'd1,  5'd5,  5'd6,  5'd7,  5'd11, 5'd12, 5'd0,  5'd0 }
    };

endpackage
`default_nettype wire

// File: rtl/knf_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knf_window
// Column shift register and fill count; captures the full 5x5 window.
// ----------------------------------------------------------------------------
module knf_window (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        en,
    input  wire                        accept,
    input  wire                        row_start,
    input  knf_pkg::pix_t [knf_pkg::WIN_DIM-1:0] col_in,
    output knf_pkg::win_t              win_out,
    output logic                       win_vld
);

    knf_pkg::pix_t [knf_pkg::WIN_DIM-1:0] col_reg [knf_pkg::STORED];
    logic [knf_pkg::CNT_W-1:0] cnt_reg;
    logic [knf_pkg::CNT_W-1:0] cnt_next;
    knf_pkg::win_t win_reg;
    knf_pkg::win_t win_next;
    logic          vld_reg;
    logic          full;

    assign full = (cnt_reg == knf_pkg::CNT_W'(knf_pkg::STORED));

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            if (row_start) begin
                cnt_next = knf_pkg::CNT_W'(1);
            end else if (!full) begin
                cnt_next = cnt_reg + knf_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < knf_pkg::WIN_DIM; r++) begin
            for (int c = 0; c < knf_pkg::STORED; c++) begin
                win_next[r*knf_pkg::WIN_DIM + c] = col_reg[c][r];
            end
            win_next[r*knf_pkg::WIN_DIM + knf_pkg::STORED] = col_in[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (en) begin
                vld_reg <= accept && !row_start && full;
            end
        end
    end

    // shift in the new column, drop the oldest
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int c = 0; c < knf_pkg::STORED - 1; c++) begin
                col_reg[c] <= col_reg[c+1];
            end
            col_reg[knf_pkg::STORED-1] <= col_in;
        end
        if (en) begin
            win_reg <= win_next;
        end
    end

    assign win_out = win_reg;
    assign win_vld = vld_reg;

endmodule
`default_nettype wire

// File: rtl/knf_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knf_lane
// One domain: sum and square-sum, then cost 9Q - S^2, two register stages.
// ----------------------------------------------------------------------------
module knf_lane (
    input  wire                aclk,
    input  wire                en,
    input  knf_pkg::dom_pix_t  pix,
    output knf_pkg::lane_res_t res
);

    logic [knf_pkg::SUM_W-1:0]  sum_next;
    logic [knf_pkg::SQ_W-1:0]   sq_next;
    logic [knf_pkg::SUM_W-1:0]  sum_reg;
    logic [knf_pkg::SQ_W-1:0]   sq_reg;
    logic [knf_pkg::COST_W-1:0] sq9;
    logic [knf_pkg::COST_W-1:0] sum_sq;
    knf_pkg::lane_res_t         res_next;
    knf_pkg::lane_res_t         res_reg;

    always_comb begin
        sum_next = '0;
        sq_next  = '0;
        for (int k = 0; k < knf_pkg::DOM_SIZE; k++) begin
            sum_next = sum_next + knf_pkg::SUM_W'(pix[k]);
            sq_next  = sq_next + knf_pkg::SQ_W'(pix[k] * pix[k]);
        end
    end

    assign sq9    = {sq_reg, 3'b000} + knf_pkg::COST_W'(sq_reg);
    assign sum_sq = knf_pkg::COST_W'(sum_reg * sum_reg);

    always_comb begin
        res_next.cost = sq9 - sum_sq;
        res_next.sum  = sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// File: rtl/knf_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knf_merge
// Least-cost domain search (first wins on ties) and division of its sum by 9.
// ----------------------------------------------------------------------------
module knf_merge (
    input  wire                    aclk,
    input  wire                    en,
    input  knf_pkg::lane_res_arr_t res,
    output knf_pkg::pix_t          pix_out
);

    localparam int GRP = 3;

    knf_pkg::lane_res_t [GRP-1:0] grp_next;
    knf_pkg::lane_res_t [GRP-1:0] grp_reg;
    knf_pkg::lane_res_t           best;
    logic [knf_pkg::SUM_W-1:0]    sum_reg;
    logic [knf_pkg::SUM_W+knf_pkg::RECIP_W-1:0] prod;

    always_comb begin
        for (int g = 0; g < GRP; g++) begin
            grp_next[g] = res[g*GRP];
            for (int k = 1; k < GRP; k++) begin
                if (res[g*GRP + k].cost < grp_next[g].cost) begin
                    grp_next[g] = res[g*GRP + k];
                end
            end
        end
    end

    always_comb begin
        best = grp_reg[0];
        for (int g = 1; g < GRP; g++) begin
            if (grp_reg[g].cost < best.cost) begin
                best = grp_reg[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grp_reg <= grp_next;
            sum_reg <= best.sum;
        end
    end

    assign prod    = sum_reg * knf_pkg::RECIP9;
    assign pix_out = prod[knf_pkg::RECIP_SH +: knf_pkg::PIX_W];

endmodule
`default_nettype wire

// File: rtl/kuwahara_nagao_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kuwahara_nagao_filter_unit
// 5x5 Kuwahara-Nagao smoothing of 8-bit pixels, one padded column per item.
// ----------------------------------------------------------------------------
// Input items carry one column of five rows on s_tdata (row 0 in the low byte)
// and a row-start flag on s_tuser. A row-start item restarts the window fill;
// from the fifth column of a row on, every item without the flag yields one
// filtered centre pixel on m_tdata. Items that only fill the window give no
// result.
// Throughput: one item per cycle while the output is not stalled. An accepted
// item passes the window capture at the accepting edge, two lane stages, two
// merge stages and the output register before its result shows on m_tvalid.
// Nine domain lanes run side by side; the merge stage picks the least-cost
// domain and divides its sum by 9 with a reciprocal multiply.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops in the same cycle; nothing is lost.
// Reset (aresetn low, synchronous) clears the fill count and all valid bits;
// the window refills from the next items accepted.
// ----------------------------------------------------------------------------
module kuwahara_nagao_filter_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // pix_row0, pix_row1, pix_row2, pix_row3, pix_row4
    input  wire         s_tuser,   // row_start
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata    // filtered_pixel
);

    localparam int PIPE = 4;

    logic                   en;
    logic                   accept;
    knf_pkg::pix_t [knf_pkg::WIN_DIM-1:0] col_in;
    knf_pkg::win_t          win;
    logic                   win_vld;
    knf_pkg::dom_pix_t      lane_pix [knf_pkg::DOM_N];
    knf_pkg::lane_res_arr_t lane_res;
    knf_pkg::pix_t          merge_pix;
    logic [PIPE-1:0]        vld_reg;
    logic                   m_tvalid_reg;
    knf_pkg::pix_t          m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_comb begin
        for (int r = 0; r < knf_pkg::WIN_DIM; r++) begin
            col_in[r] = s_tdata[r*knf_pkg::PIX_W +: knf_pkg::PIX_W];
        end
    end

    knf_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .accept    (accept),
        .row_start (s_tuser),
        .col_in    (col_in),
        .win_out   (win),
        .win_vld   (win_vld)
    );

    for (genvar d = 0; d < knf_pkg::DOM_N; d++) begin : g_lane
        for (genvar k = 0; k < knf_pkg::DOM_SIZE; k++) begin : g_tap
            if (k < int'(knf_pkg::DOM_LEN[d])) begin : g_pix
                assign lane_pix[d][k] = win[knf_pkg::DOM_POS[d][k]];
            end else begin : g_pad
                assign lane_pix[d][k] = '0;
            end
        end

        knf_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .pix  (lane_pix[d]),
            .res  (lane_res[d])
        );
    end

    knf_merge u_merge (
        .aclk    (aclk),
        .en      (en),
        .res     (lane_res),
        .pix_out (merge_pix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[PIPE-2:0], win_vld};
            m_tvalid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= merge_pix;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
